// ===== hdl/utv_pkg.sv =====
// Shared types, constants and the helper function of the UTF-8 text validator.
package utv_pkg;

    localparam int unsigned DataW    = 8;
    localparam int unsigned LenW     = 16;
    localparam int unsigned CountW   = 17;
    localparam int unsigned ScalarW  = 21;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    localparam logic [CountW-1:0]  CountMax     = 17'h1FFFF;
    localparam logic [LenW-1:0]    MaxLenReset  = 16'd4096;

    localparam logic [DataW-1:0]   CharDel      = 8'h7F;
    localparam logic [DataW-1:0]   CharSpace    = 8'h20;
    localparam logic [DataW-1:0]   Lead2Lo      = 8'hC2;
    localparam logic [DataW-1:0]   Lead2Hi      = 8'hDF;
    localparam logic [DataW-1:0]   Lead3Lo      = 8'hE0;
    localparam logic [DataW-1:0]   Lead3Hi      = 8'hEF;
    localparam logic [DataW-1:0]   Lead4Lo      = 8'hF0;
    localparam logic [DataW-1:0]   Lead4Hi      = 8'hF4;

    localparam logic [ScalarW-1:0] ScalarMin2   = 21'h00080;
    localparam logic [ScalarW-1:0] ScalarMin3   = 21'h00800;
    localparam logic [ScalarW-1:0] ScalarMin4   = 21'h10000;
    localparam logic [ScalarW-1:0] ScalarMax    = 21'h10FFFF;
    localparam logic [ScalarW-1:0] SurrogateLo  = 21'h0D800;
    localparam logic [ScalarW-1:0] SurrogateHi  = 21'h0DFFF;
    localparam logic [ScalarW-1:0] C1Lo         = 21'h00080;
    localparam logic [ScalarW-1:0] C1Hi         = 21'h0009F;

    // register word index, taken from paddr[2]
    localparam logic RegMaxLength = 1'b0;

    typedef enum logic [1:0] {
        t_min_2byte = 2'd0,
        t_min_3byte = 2'd1,
        t_min_4byte = 2'd2,
        t_min_4alt  = 2'd3
    } t_min_class;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             last_byte;
    } t_item;

    typedef struct packed {
        logic [CountW-1:0]  byte_count;
        logic [1:0]         bytes_pending;
        logic [ScalarW-1:0] scalar_acc;
        t_min_class         min_class;
        logic               error_seen;
    } t_state;

    function automatic logic [ScalarW-1:0] class_minimum(input t_min_class cls);
        logic [ScalarW-1:0] m;
        unique case (cls)
            t_min_2byte: m = ScalarMin2;
            t_min_3byte: m = ScalarMin3;
            default:     m = ScalarMin4;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/utv_cfg_regs.sv =====
// APB configuration register block holding the maximum text length.
module utv_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utv_pkg::ApbAddrW-1:0]    paddr,
    input  logic [utv_pkg::ApbDataW-1:0]    pwdata,
    output logic [utv_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready,
    output logic [utv_pkg::LenW-1:0]        o_max_length
);

    logic [utv_pkg::LenW-1:0] r_max_length;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= utv_pkg::MaxLenReset;
        end else if (w_wr && (paddr[2] == utv_pkg::RegMaxLength)) begin
            r_max_length <= pwdata[utv_pkg::LenW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == utv_pkg::RegMaxLength) begin
            prdata[utv_pkg::LenW-1:0] = r_max_length;
        end
    end

    assign o_max_length = r_max_length;

endmodule

// ===== hdl/utv_checker.sv =====
// Per-text decode state and the one-byte UTF-8 check with verdict.
module utv_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  utv_pkg::t_item              i_item,
    input  logic [utv_pkg::LenW-1:0]    i_max_length,
    output logic                        o_verdict
);

    utv_pkg::t_state          r_state;
    utv_pkg::t_state          n_state;
    utv_pkg::t_state          w_upd;
    logic [utv_pkg::DataW-1:0] w_c;
    logic [utv_pkg::ScalarW-1:0] w_acc;

    assign w_c   = i_item.data_byte;
    assign w_acc = {r_state.scalar_acc[utv_pkg::ScalarW-7:0], w_c[5:0]};

    always_comb begin
        w_upd = r_state;
        if (r_state.byte_count != utv_pkg::CountMax) begin
            w_upd.byte_count = r_state.byte_count + 1'b1;
        end
        if (!r_state.error_seen) begin
            if (r_state.bytes_pending == 2'd0) begin
                if (!w_c[7]) begin
                    if (w_c < utv_pkg::CharSpace || w_c == utv_pkg::CharDel) begin
                        w_upd.error_seen = 1'b1;
                    end
                end else if (w_c >= utv_pkg::Lead2Lo && w_c <= utv_pkg::Lead2Hi) begin
                    w_upd.bytes_pending = 2'd1;
                    w_upd.scalar_acc    = {16'd0, w_c[4:0]};
                    w_upd.min_class     = utv_pkg::t_min_2byte;
                end else if (w_c >= utv_pkg::Lead3Lo && w_c <= utv_pkg::Lead3Hi) begin
                    w_upd.bytes_pending = 2'd2;
                    w_upd.scalar_acc    = {17'd0, w_c[3:0]};
                    w_upd.min_class     = utv_pkg::t_min_3byte;
                end else if (w_c >= utv_pkg::Lead4Lo && w_c <= utv_pkg::Lead4Hi) begin
                    w_upd.bytes_pending = 2'd3;
                    w_upd.scalar_acc    = {18'd0, w_c[2:0]};
                    w_upd.min_class     = utv_pkg::t_min_4byte;
                end else begin
                    w_upd.error_seen = 1'b1;
                end
            end else if (w_c[7:6] != 2'b10) begin
                w_upd.error_seen = 1'b1;
            end else begin
                w_upd.scalar_acc    = w_acc;
                w_upd.bytes_pending = r_state.bytes_pending - 2'd1;
                // check the finished scalar on its closing continuation byte
                if (r_state.bytes_pending == 2'd1) begin
                    if (w_acc < utv_pkg::class_minimum(r_state.min_class) ||
                        w_acc > utv_pkg::ScalarMax ||
                        (w_acc >= utv_pkg::SurrogateLo && w_acc <= utv_pkg::SurrogateHi) ||
                        (w_acc >= utv_pkg::C1Lo && w_acc <= utv_pkg::C1Hi)) begin
                        w_upd.error_seen = 1'b1;
                    end
                end
            end
        end
    end

    assign o_verdict = !w_upd.error_seen && (w_upd.bytes_pending == 2'd0) &&
                       (w_upd.byte_count <= {1'b0, i_max_length});

    always_comb begin
        n_state = r_state;
        if (i_step) begin
            // clear everything after the final byte of a text
            n_state = i_item.last_byte ? '0 : w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/utf8_text_validator.sv =====
// Streaming UTF-8 text validator: input register, byte checker, verdict register.
//
// Bytes of a text enter one per transfer on the input channel, the final byte marked
// by i_last_byte; a single verdict transfer (o_text_valid) follows each final byte,
// and no other byte produces a result. The block takes one byte per clock: each byte
// sits in the input register while the checker updates its decode state and, for a
// final byte, writes the verdict register, from which the verdict leaves the block.
// Throughput drops below one byte per clock only while a verdict waits in the output
// register and the next final byte needs that slot.
// The maximum length register sits at byte address 0 of the APB port and resets to
// 4096; write it only while no text is in flight.
module utf8_text_validator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [utv_pkg::DataW-1:0]       i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_text_valid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utv_pkg::ApbAddrW-1:0]    paddr,
    input  logic [utv_pkg::ApbDataW-1:0]    pwdata,
    output logic [utv_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready
);

    logic                       r_in_valid;
    utv_pkg::t_item             r_in;
    logic                       r_out_valid;
    logic                       r_out_text_valid;
    logic [utv_pkg::LenW-1:0]   w_max_length;
    logic                       w_verdict;
    logic                       w_out_free;
    logic                       w_move;
    logic                       w_accept;

    utv_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (w_max_length)
    );

    utv_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_move),
        .i_item       (r_in),
        .i_max_length (w_max_length),
        .o_verdict    (w_verdict)
    );

    // a non-final byte never needs the output slot
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_in_valid && (!r_in.last_byte || w_out_free);
    assign o_stall    = r_in_valid && !w_move;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.data_byte <= i_data_byte;
            r_in.last_byte <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move && r_in.last_byte) begin
            r_out_text_valid <= w_verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_text_valid = r_out_text_valid;

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in.last_byte) |=> o_valid)
        else $error("final byte did not load a verdict");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with empty input register");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_move && r_in.last_byte))
        else $error("verdict appeared without a final byte");

endmodule

// ===== sim/utf8_text_validator_checker.sv =====
// Verdict checker for the UTF-8 text validator: watches both channels and the APB port.
module utf8_text_validator_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [utv_pkg::DataW-1:0]    i_data_byte,
    input  logic                         i_last_byte,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_text_valid,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [utv_pkg::ApbAddrW-1:0] i_paddr,
    input  logic [utv_pkg::ApbDataW-1:0] i_pwdata,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_verdicts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [utv_pkg::CountW-1:0]  count;
        logic [1:0]                  pending;
        logic [utv_pkg::ScalarW-1:0] acc;
        utv_pkg::t_min_class         floor_class;
        logic                        bad;
    } t_decode_state;

    t_decode_state              text_state;
    logic [utv_pkg::LenW-1:0]   length_limit;
    logic                       verdict_q[$];
    int unsigned                fail_total;
    int unsigned                verdicts_seen;

    function automatic t_decode_state absorb_byte(input t_decode_state s,
                                                  input logic [utv_pkg::DataW-1:0] c);
        t_decode_state               n;
        logic [utv_pkg::ScalarW-1:0] floor_val;
        n = s;
        if (n.count != utv_pkg::CountMax) n.count = n.count + 1'b1;
        // once a text has failed, later bytes are only counted
        if (!s.bad) begin
            if (s.pending == 2'd0) begin
                if (c < 8'h80) begin
                    if (c < utv_pkg::CharSpace || c == utv_pkg::CharDel) n.bad = 1'b1;
                end else if (c >= utv_pkg::Lead2Lo && c <= utv_pkg::Lead2Hi) begin
                    n.pending     = 2'd1;
                    n.acc         = utv_pkg::ScalarW'(c[4:0]);
                    n.floor_class = utv_pkg::t_min_2byte;
                end else if (c >= utv_pkg::Lead3Lo && c <= utv_pkg::Lead3Hi) begin
                    n.pending     = 2'd2;
                    n.acc         = utv_pkg::ScalarW'(c[3:0]);
                    n.floor_class = utv_pkg::t_min_3byte;
                end else if (c >= utv_pkg::Lead4Lo && c <= utv_pkg::Lead4Hi) begin
                    n.pending     = 2'd3;
                    n.acc         = utv_pkg::ScalarW'(c[2:0]);
                    n.floor_class = utv_pkg::t_min_4byte;
                end else begin
                    n.bad = 1'b1;
                end
            end else if (c[7:6] != 2'b10) begin
                n.bad = 1'b1;
            end else begin
                n.acc     = {s.acc[utv_pkg::ScalarW-7:0], c[5:0]};
                n.pending = s.pending - 2'd1;
                if (n.pending == 2'd0) begin
                    case (s.floor_class)
                        utv_pkg::t_min_2byte: floor_val = utv_pkg::ScalarMin2;
                        utv_pkg::t_min_3byte: floor_val = utv_pkg::ScalarMin3;
                        default:              floor_val = utv_pkg::ScalarMin4;
                    endcase
                    if (n.acc < floor_val || n.acc > utv_pkg::ScalarMax ||
                        (n.acc >= utv_pkg::SurrogateLo && n.acc <= utv_pkg::SurrogateHi) ||
                        (n.acc >= utv_pkg::C1Lo && n.acc <= utv_pkg::C1Hi))
                        n.bad = 1'b1;
                end
            end
        end
        return n;
    endfunction

    task automatic flag_mismatch(input string msg);
        fail_total++;
        if (fail_total <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_decode_state next_state;
        logic          predicted;
        if (!i_rst_n) begin
            text_state   = '0;
            length_limit = utv_pkg::MaxLenReset;
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("verdict %0d: text_valid=%0b with none outstanding",
                                            verdicts_seen, i_text_valid));
                end else begin
                    predicted = verdict_q.pop_front();
                    if (i_text_valid !== predicted)
                        flag_mismatch($sformatf("verdict %0d: expected text_valid=%0b, got %0b",
                                                verdicts_seen, predicted, i_text_valid));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == utv_pkg::RegMaxLength)
                length_limit = i_pwdata[utv_pkg::LenW-1:0];
            if (i_in_valid && !i_in_stall) begin
                next_state = absorb_byte(text_state, i_data_byte);
                if (i_last_byte) begin
                    predicted = !next_state.bad && next_state.pending == 2'd0 &&
                                next_state.count <= {1'b0, length_limit};
                    verdict_q = {verdict_q, predicted};
                    text_state = '0;
                end else begin
                    text_state = next_state;
                end
            end
        end
        o_fail_count       <= fail_total;
        o_verdicts_pending <= verdict_q.size();
    end

endmodule

// ===== sim/utf8_text_validator_tb.sv =====
// Top of the UTF-8 text validator testbench: clock, reset, stimulus and the verdict.
module utf8_text_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LimitCycles = 1_000_000;
    localparam int unsigned HoldCycles  = 200;
    localparam int unsigned DrainCycles = 6;

    typedef enum int {
        FaultCtrl, FaultBadLead, FaultNoCont, FaultOverlong,
        FaultAboveMax, FaultSurrogate, FaultC1, FaultTrunc
    } t_fault;

    typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} t_stall_mode;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [utv_pkg::DataW-1:0]    i_data_byte;
    logic                         i_last_byte;
    logic                         o_valid;
    logic                         i_stall;
    logic                         o_text_valid;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [utv_pkg::ApbAddrW-1:0] paddr;
    logic [utv_pkg::ApbDataW-1:0] pwdata;
    logic [utv_pkg::ApbDataW-1:0] prdata;
    logic                         pready;

    int unsigned fail_count;
    int unsigned verdicts_pending;
    int unsigned cycle_count;
    int unsigned holds_asked;
    int unsigned holds_served;
    int unsigned burst_left;
    bit          gaps_on;
    logic [7:0]  text_bytes[$];

    utf8_text_validator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_text_valid (o_text_valid),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    utf8_text_validator_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_text_valid       (o_text_valid),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_fail_count       (fail_count),
        .o_verdicts_pending (verdicts_pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
        while (cycle_count < LimitCycles) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stall patterns, plus a long hold-off whenever one is asked for.
    initial begin
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        i_stall      = 1'b0;
        holds_served = 0;
        mode         = StallNone;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left    = HoldCycles - 1;
                i_stall      = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    StallNone:  i_stall = 1'b0;
                    StallLight: i_stall = ($urandom_range(0, 3) == 0);
                    StallHeavy: i_stall = ($urandom_range(0, 3) != 0);
                    default:    i_stall = ((tick % 5) < 2);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left != 0) burst_left--;
    endtask

    task automatic send_text();
        foreach (text_bytes[k]) send_byte(text_bytes[k], k == text_bytes.size() - 1);
    endtask

    // Drop valid and hold until every outstanding verdict has been transferred.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (verdicts_pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_max_length(input int unsigned value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {utv_pkg::RegMaxLength, 2'b00};
        pwdata  = utv_pkg::ApbDataW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] non_cont_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b = b ^ 8'h40;
        return b;
    endfunction

    function automatic logic [7:0] lead_byte(input int unsigned extra);
        if (extra == 1) return 8'($urandom_range(32'hC2, 32'hDF));
        if (extra == 2) return 8'($urandom_range(32'hE0, 32'hEF));
        return 8'($urandom_range(32'hF0, 32'hF4));
    endfunction

    function automatic void add_scalar(input int unsigned s);
        if (s < 32'h80) begin
            add_byte(s[7:0]);
        end else if (s < 32'h800) begin
            add_byte({3'b110, s[10:6]});
            add_byte({2'b10, s[5:0]});
        end else if (s < 32'h10000) begin
            add_byte({4'b1110, s[15:12]});
            add_byte({2'b10, s[11:6]});
            add_byte({2'b10, s[5:0]});
        end else begin
            add_byte({5'b11110, s[20:18]});
            add_byte({2'b10, s[17:12]});
            add_byte({2'b10, s[11:6]});
            add_byte({2'b10, s[5:0]});
        end
    endfunction

    function automatic void add_random_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)      add_scalar($urandom_range(32'h20, 32'h7E));
        else if (r < 60) add_scalar($urandom_range(32'h80, 32'h7FF));
        else if (r < 80) add_scalar($urandom_range(32'h800, 32'hFFFF));
        else             add_scalar($urandom_range(32'h10000, 32'h10FFFF));
    endfunction

    function automatic void add_fault(input t_fault f);
        int unsigned k;
        int unsigned b;
        case (f)
            FaultCtrl: begin
                b = $urandom_range(0, 32);
                add_byte((b == 32) ? utv_pkg::CharDel : 8'(b));
            end
            FaultBadLead: begin
                if ($urandom_range(0, 1)) add_byte(8'($urandom_range(32'h80, 32'hC1)));
                else                      add_byte(8'($urandom_range(32'hF5, 32'hFF)));
            end
            FaultNoCont: begin
                k = $urandom_range(1, 3);
                add_byte(lead_byte(k));
                repeat ($urandom_range(0, k - 1)) add_byte(cont_byte());
                add_byte(non_cont_byte());
            end
            FaultOverlong: begin
                if ($urandom_range(0, 1)) begin
                    add_byte(utv_pkg::Lead3Lo);
                    add_byte(8'($urandom_range(32'h80, 32'h9F)));
                    add_byte(cont_byte());
                end else begin
                    add_byte(utv_pkg::Lead4Lo);
                    add_byte(8'($urandom_range(32'h80, 32'h8F)));
                    add_byte(cont_byte());
                    add_byte(cont_byte());
                end
            end
            FaultAboveMax: begin
                add_byte(utv_pkg::Lead4Hi);
                add_byte(8'($urandom_range(32'h90, 32'hBF)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            FaultSurrogate: begin
                add_byte(8'hED);
                add_byte(8'($urandom_range(32'hA0, 32'hBF)));
                add_byte(cont_byte());
            end
            FaultC1: begin
                add_byte(utv_pkg::Lead2Lo);
                add_byte(8'($urandom_range(32'h80, 32'h9F)));
            end
            default: begin
                // sequence cut off by the end of the text
                k = $urandom_range(1, 3);
                add_byte(lead_byte(k));
                repeat ($urandom_range(0, k - 1)) add_byte(cont_byte());
            end
        endcase
    endfunction

    function automatic void build_random_text(input int unsigned max_chars);
        int unsigned n;
        int unsigned at;
        bit          inject;
        t_fault      f;
        text_bytes.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            return;
        end
        n      = $urandom_range(1, max_chars);
        inject = ($urandom_range(0, 99) < 35);
        f      = t_fault'($urandom_range(0, 7));
        at     = $urandom_range(0, n);
        for (int unsigned i = 0; i <= n; i++) begin
            if (inject && f != FaultTrunc && i == at) add_fault(f);
            if (i < n) add_random_char();
        end
        if (inject && f == FaultTrunc) add_fault(f);
    endfunction

    task automatic run_random(input int unsigned budget, input int unsigned max_chars);
        int unsigned sent;
        sent = 0;
        while (sent < budget) begin
            build_random_text(max_chars);
            send_text();
            sent += text_bytes.size();
        end
    endtask

    // Printable ASCII only, so the length check alone decides the verdict.
    task automatic send_long(input int unsigned len);
        gaps_on = 1'b0;
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(32'h20, 32'h7E)), i == len - 1);
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        holds_asked = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed texts under the reset length limit
        text_bytes = '{8'h41};                      send_text();
        text_bytes = '{8'h20};                      send_text();
        text_bytes = '{8'h1F};                      send_text();
        text_bytes = '{8'h7F};                      send_text();
        text_bytes = '{8'h80};                      send_text();
        text_bytes = '{8'hC1};                      send_text();
        text_bytes = '{8'hF5};                      send_text();
        text_bytes = '{8'hC2, 8'h9F};               send_text();
        text_bytes = '{8'hED, 8'hA0, 8'h80};        send_text();
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text();
        text_bytes = '{8'hE0, 8'h9F, 8'hBF};        send_text();
        text_bytes = '{8'hC3, 8'h41};               send_text();
        text_bytes = '{8'hE2, 8'h82};               send_text();
        run_random(250, 8);
        wait_drained();

        // texts right at and just past the length limit
        write_max_length(32);
        send_long(32);
        send_long(33);
        wait_drained();

        write_max_length(1);
        run_random(150, 2);
        wait_drained();

        // long receiver hold-off while texts keep coming
        write_max_length(5);
        holds_asked++;
        run_random(400, 6);
        wait_drained();

        write_max_length(0);
        run_random(100, 4);
        wait_drained();

        repeat (3) begin
            write_max_length($urandom_range(1, 24));
            run_random(200, 8);
            wait_drained();
        end

        write_max_length(65535);
        run_random(250, 10);
        wait_drained();

        if (fail_count == 0 && verdicts_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
